### src/sbb_pkg.sv
// Package for the subsampled box blur pixel core: shared types and constants.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbb_pkg;

    // Fixed field widths of the item and configuration interfaces.
    localparam int COORD_W = 7;
    localparam int RGB_W   = 24;
    localparam int CH_W    = 8;
    localparam int DIM_W   = 8;
    localparam int RAD_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Signed window coordinate: spans center minus radius up to center plus radius minus two.
    localparam int POS_W = 9;

    // Channel sums hold up to 15*15 samples of 255; the divisor is the count plus one.
    localparam int SUM_W   = 16;
    localparam int DIVR_W  = 8;
    localparam int STEP_W  = $clog2(SUM_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 8'd128;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 8'd128;
    localparam logic [RAD_W-1:0] BLUR_RADIUS_RST   = 4'd7;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch the window origin, clear sums
        logic write;     // store the input pixel
        logic step;      // visit one window position
        logic div_load;  // load the dividers from the sums
        logic div_step;  // one restoring division step
        logic load_out;  // move the quotients into the output register
    } sbb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radius_zero;
        logic last_step;
        logic div_last;
        logic out_free;
    } sbb_stat_t;

    // Controller states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_HOLD  = 6'b100000
    } sbb_state_t;

endpackage

`default_nettype wire

### src/sbb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
`default_nettype none

module sbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/sbb_ctrl.sv
// Controller state machine of the subsampled box blur pixel core.
// Depends on sbb_pkg for the command, status and state types.
`default_nettype none

module sbb_ctrl
    import sbb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_req_type,
    output logic           s_ready,
    input  wire sbb_stat_t stat,
    output sbb_cmd_t       cmd,
    output sbb_state_t     state
);

    sbb_state_t state_reg, state_next;
    logic       accept;

    assign state   = state_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = stat.radius_zero ? ST_DRAIN : ST_SCAN;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (stat.last_step) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last frame store read lands in the sums here.
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/sbb_dpath.sv
// Datapath of the subsampled box blur pixel core: configuration, frame store,
// window walk, channel sums, bit-serial dividers and output register.
// Depends on sbb_pkg and sbb_ram.
`default_nettype none

module sbb_dpath
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [COORD_W-1:0]    s_pos_x,
    input  wire logic [COORD_W-1:0]    s_pos_y,
    input  wire logic [RGB_W-1:0]      s_pixel_rgb,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [RGB_W-1:0]      m_avg_rgb,
    input  wire sbb_cmd_t              cmd,
    output sbb_stat_t                  stat
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);

    // Configuration registers.
    logic [DIM_W-1:0] sw_reg;
    logic [DIM_W-1:0] sh_reg;
    logic [RAD_W-1:0] r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= SCREEN_WIDTH_RST;
            sh_reg <= SCREEN_HEIGHT_RST;
            r_reg  <= BLUR_RADIUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: sh_reg <= cfg_data;
                CFG_BLUR_RADIUS:   r_reg  <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Window walk registers.
    logic signed [POS_W-1:0] col_reg, row_reg, base_y_reg;
    logic [RAD_W-1:0]        cnt_x_reg, cnt_y_reg;
    logic [RAD_W-1:0]        r_last;
    logic                    y_wrap;
    logic                    kept_reg;
    logic                    in_bounds;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_in_range;
    logic [RGB_W-1:0]        rd_data;

    assign r_last = r_reg - RAD_W'(1);
    assign y_wrap = (cnt_y_reg == r_last);

    // A sample counts only at a column and row above zero, inside the screen and inside the store.
    assign in_bounds = (col_reg > 0) && (row_reg > 0)
                    && (col_reg[DIM_W-1:0] < sw_reg) && (row_reg[DIM_W-1:0] < sh_reg)
                    && (32'(col_reg[DIM_W-1:0]) < 32'(MAX_WIDTH))
                    && (32'(row_reg[DIM_W-1:0]) < 32'(MAX_HEIGHT));

    assign rd_addr = AW'(row_reg[DIM_W-1:0]) * ROW_PITCH + AW'(col_reg[DIM_W-1:0]);
    assign wr_addr = AW'(s_pos_y) * ROW_PITCH + AW'(s_pos_x);
    assign wr_in_range = (32'(s_pos_x) < 32'(MAX_WIDTH)) && (32'(s_pos_y) < 32'(MAX_HEIGHT));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            col_reg    <= $signed({2'b00, s_pos_x}) - $signed({5'b00000, r_reg});
            row_reg    <= $signed({2'b00, s_pos_y}) - $signed({5'b00000, r_reg});
            base_y_reg <= $signed({2'b00, s_pos_y}) - $signed({5'b00000, r_reg});
            cnt_x_reg  <= '0;
            cnt_y_reg  <= '0;
        end else if (cmd.step) begin
            if (y_wrap) begin
                row_reg   <= base_y_reg;
                cnt_y_reg <= '0;
                col_reg   <= col_reg + POS_W'(2);
                cnt_x_reg <= cnt_x_reg + RAD_W'(1);
            end else begin
                row_reg   <= row_reg + POS_W'(2);
                cnt_y_reg <= cnt_y_reg + RAD_W'(1);
            end
        end
    end

    // Marks a read issued in the previous cycle whose data must be summed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= 1'b0;
        end else begin
            kept_reg <= cmd.step && in_bounds;
        end
    end

    // Frame store.
    sbb_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .aclk  (aclk),
        .we    (cmd.write && wr_in_range),
        .waddr (wr_addr),
        .wdata (s_pixel_rgb),
        .re    (cmd.step && in_bounds),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Channel sums and divisor; lane 0 is red, 1 green, 2 blue.
    logic [SUM_W-1:0]  sum_reg [3];
    logic [DIVR_W-1:0] divr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= '0;
            end
            divr_reg <= DIVR_W'(1);
        end else if (kept_reg) begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= sum_reg[k]
                            + SUM_W'(rd_data[RGB_W-1-k*CH_W -: CH_W]);
            end
            divr_reg <= divr_reg + DIVR_W'(1);
        end
    end

    // Restoring dividers, one quotient bit per cycle in each lane.
    logic [SUM_W-1:0]  quo_reg [3];
    logic [DIVR_W-1:0] rem_reg [3];
    logic [STEP_W-1:0] div_cnt_reg;
    logic [DIVR_W:0]   rem_sh  [3];
    logic              q_bit   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_sh[k] = {rem_reg[k], quo_reg[k][SUM_W-1]};
            q_bit[k]  = (rem_sh[k] >= {1'b0, divr_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            for (int k = 0; k < 3; k++) begin
                quo_reg[k] <= sum_reg[k];
                rem_reg[k] <= '0;
            end
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                quo_reg[k] <= {quo_reg[k][SUM_W-2:0], q_bit[k]};
                rem_reg[k] <= q_bit[k] ? DIVR_W'(rem_sh[k] - {1'b0, divr_reg})
                                       : rem_sh[k][DIVR_W-1:0];
            end
            div_cnt_reg <= div_cnt_reg + STEP_W'(1);
        end
    end

    // Output register: holds a result until its transfer.
    logic             m_valid_reg;
    logic [RGB_W-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {quo_reg[0][CH_W-1:0], quo_reg[1][CH_W-1:0], quo_reg[2][CH_W-1:0]};
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_avg_rgb = out_reg;

    // Status back to the controller.
    assign stat.radius_zero = (r_reg == '0);
    assign stat.last_step   = (cnt_x_reg == r_last) && y_wrap;
    assign stat.div_last    = (div_cnt_reg == STEP_W'(SUM_W - 1));
    assign stat.out_free    = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

### src/subsampled_box_blur_pixel_core.sv
// Subsampled box blur pixel core, top level.
// Depends on sbb_pkg, sbb_ctrl, sbb_dpath and sbb_ram.
//
// Usage:
//   The input channel (s_*) carries write and query items. A write stores
//   s_pixel_rgb at (s_pos_x, s_pos_y) and gives no result; positions outside
//   the store are dropped. A query averages every second pixel of the window
//   around (s_pos_x, s_pos_y) and returns one packed color on the m_* channel.
//   The configuration port is written with cfg_wr_en, cfg_index and cfg_data
//   while the block is idle.
// Sequence:
//   A write is done with its transfer. A query runs through the transfer,
//   a scan of one window position per cycle through the single frame store
//   read port (skipped at radius zero), the collection of the last read, the
//   divider load, the bit-serial dividers and the output load.
// Reset and stalls:
//   Reset returns the controller to idle, empties the output register and
//   restores the configuration; the frame store keeps undefined contents
//   until written. A stalled receiver holds the result in the output register
//   while the next item is accepted; a second query waits before its load.
`default_nettype none

module subsampled_box_blur_pixel_core
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [COORD_W-1:0]    s_pos_x,
    input  wire logic [COORD_W-1:0]    s_pos_y,
    input  wire logic [RGB_W-1:0]      s_pixel_rgb,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [RGB_W-1:0]      m_avg_rgb
);

    sbb_cmd_t   cmd;
    sbb_stat_t  stat;
    sbb_state_t state;

    // Controller.
    sbb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .stat       (stat),
        .cmd        (cmd),
        .state      (state)
    );

    // Datapath.
    sbb_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pixel_rgb (s_pixel_rgb),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_avg_rgb   (m_avg_rgb),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A query transfer keeps the block busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_QUERY)) |=> !s_ready)
        else $error("block ready right after a query transfer");

    // After a write transfer the block is ready again in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_WRITE)) |=> s_ready)
        else $error("block not ready after a write transfer");

    // A result is loaded only at the end of a query, never from idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (state == ST_HOLD) && stat.out_free)
        else $error("output loaded outside the hold state");

    // A new result appears only when the block was busy just before it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was idle");

endmodule

`default_nettype wire
